// ===== src/pdll_pkg.sv =====
// Shared constants and codes for the positional doubly linked list.
// Pool size, slot and count widths, action and status codes.
// No dependencies.
package pdll_pkg;

  localparam int CAPACITY = 256;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 9;
  localparam int POS_W    = 16;
  localparam int VAL_W    = 32;
  localparam int IN_W     = 56;
  localparam int OUT_W    = 80;

  typedef enum logic [1:0] {
    ACT_HEAD = 2'd0,
    ACT_TAIL = 2'd1,
    ACT_INS  = 2'd2,
    ACT_DEL  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_POS0  = 2'd3
  } status_t;

endpackage

// ===== src/positional_doubly_linked_list.sv =====
// Top level of the positional doubly linked list over a fixed node pool.
// Depends on pdll_pkg and four pdll_ram instances.
//
// The block keeps an ordered list of signed 32-bit items in a pool of CAPACITY
// slots and runs one operation per input beat: insert at head, insert at tail,
// insert at a 1-based position, or delete at a position. Every input beat gives
// one output beat with status, length, a nonempty flag and the head and tail
// values (zero when empty). One item is in work at a time. Refused operations
// go straight to the result. A positional insert or delete walks the next-link
// memory from the head one node per cycle through its single read port. After
// each result the block returns to idle before the next accept.
// A waiting result does not block the next accept; a new result waits until
// the previous one is taken. No clearing pass after reset: the block is ready
// as soon as reset is released.
module positional_doubly_linked_list
  import pdll_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // action[1:0], position[17:2], item_value[49:18]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // status[1:0], length[10:2], nonempty[11],
                                       // head_value[43:12], tail_value[75:44]
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_WALK, S_POP, S_LINK, S_DMID, S_DHEAD, S_DTAIL, S_VAL, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    K_FIRST, K_HEAD, K_TAIL, K_MID
  } kind_t;

  state_t                   state_r, state_nxt;
  kind_t                    kind_r, kind_nxt;
  status_t                  status_r, status_nxt;
  action_t                  act_r, act_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic signed [VAL_W-1:0]  val_r, val_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         free_r, free_nxt;
  logic [CNT_W-1:0]         min_r, min_nxt;
  logic [SLOT_W-1:0]        head_r, head_nxt;
  logic [SLOT_W-1:0]        tail_r, tail_nxt;
  logic signed [VAL_W-1:0]  hval_r, hval_nxt;
  logic signed [VAL_W-1:0]  tval_r, tval_nxt;
  logic [SLOT_W-1:0]        cur_r, cur_nxt;
  logic [SLOT_W-1:0]        steps_r, steps_nxt;
  logic [SLOT_W-1:0]        left_r, left_nxt;
  logic [SLOT_W-1:0]        right_r, right_nxt;
  logic [SLOT_W-1:0]        new_r, new_nxt;
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]         out_tdata_r, out_tdata_nxt;

  logic                     sv_we, nx_we, pv_we, fs_we;
  logic [SLOT_W-1:0]        sv_waddr, nx_waddr, pv_waddr, fs_waddr;
  logic [SLOT_W-1:0]        sv_raddr, nx_raddr, pv_raddr, fs_raddr;
  logic [VAL_W-1:0]         sv_wdata, sv_rdata;
  logic [SLOT_W-1:0]        nx_wdata, pv_wdata, fs_wdata;
  logic [SLOT_W-1:0]        nx_rdata, pv_rdata, fs_rdata;

  logic                     empty, full, pos_zero, pos_one, pos_end, fresh;
  logic [CNT_W-1:0]         pop_idx;
  logic [SLOT_W-1:0]        pop_slot;
  logic                     has_room;

  assign empty    = (count_r == '0);
  assign full     = (free_r == '0);
  assign pos_zero = (pos_r == '0);
  assign pos_one  = (pos_r == POS_W'(1));
  assign pos_end  = (pos_r >= POS_W'(count_r));
  assign pop_idx  = free_r - CNT_W'(1);
  assign fresh    = (pop_idx < min_r);
  assign pop_slot = fresh ? pop_idx[SLOT_W-1:0] : fs_rdata;
  assign has_room = (free_r < CNT_W'(CAPACITY));

  pdll_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_slot_value (
    .clk(clk), .we(sv_we), .waddr(sv_waddr), .wdata(sv_wdata),
    .raddr(sv_raddr), .rdata(sv_rdata)
  );

  pdll_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_next_link (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata)
  );

  pdll_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_prev_link (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(pv_raddr), .rdata(pv_rdata)
  );

  pdll_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free_slots (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(fs_raddr), .rdata(fs_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    status_nxt     = status_r;
    act_nxt        = act_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    count_nxt      = count_r;
    free_nxt       = free_r;
    min_nxt        = min_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    hval_nxt       = hval_r;
    tval_nxt       = tval_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    new_nxt        = new_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;
    in_tready      = 1'b0;

    sv_we = 1'b0; sv_waddr = pop_slot; sv_wdata = val_r; sv_raddr = nx_rdata;
    nx_we = 1'b0; nx_waddr = pop_slot; nx_wdata = head_r; nx_raddr = cur_r;
    pv_we = 1'b0; pv_waddr = head_r;   pv_wdata = pop_slot; pv_raddr = tail_r;
    fs_we = 1'b0; fs_waddr = free_r[SLOT_W-1:0]; fs_wdata = head_r;
    fs_raddr = pop_idx[SLOT_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          act_nxt   = action_t'(in_tdata[1:0]);
          pos_nxt   = in_tdata[17:2];
          val_nxt   = in_tdata[49:18];
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        status_nxt = ST_DONE;
        state_nxt  = S_POP;
        unique case (act_r)
          ACT_HEAD: begin
            if (empty) begin
              kind_nxt = K_FIRST;
            end else if (full) begin
              status_nxt = ST_FULL;
              state_nxt  = S_OUT;
            end else begin
              kind_nxt = K_HEAD;
            end
          end
          ACT_TAIL: begin
            if (empty) begin
              kind_nxt = K_FIRST;
            end else if (full) begin
              status_nxt = ST_FULL;
              state_nxt  = S_OUT;
            end else begin
              kind_nxt = K_TAIL;
            end
          end
          ACT_INS: begin
            priority if (empty) begin
              kind_nxt = K_FIRST;
            end else if (pos_zero) begin
              status_nxt = ST_POS0;
              state_nxt  = S_OUT;
            end else if (full) begin
              status_nxt = ST_FULL;
              state_nxt  = S_OUT;
            end else if (pos_one) begin
              kind_nxt = K_HEAD;
            end else if (pos_end) begin
              kind_nxt = K_TAIL;
            end else begin
              nx_raddr  = head_r;
              cur_nxt   = head_r;
              steps_nxt = SLOT_W'(pos_r - POS_W'(2));
              state_nxt = S_WALK;
            end
          end
          ACT_DEL: begin
            priority if (empty) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_OUT;
            end else if (pos_zero) begin
              status_nxt = ST_POS0;
              state_nxt  = S_OUT;
            end else if (pos_one && count_r == CNT_W'(1)) begin
              fs_we     = has_room;
              fs_wdata  = head_r;
              free_nxt  = has_room ? free_r + CNT_W'(1) : free_r;
              count_nxt = '0;
              head_nxt  = '0;
              tail_nxt  = '0;
              state_nxt = S_OUT;
            end else if (pos_one) begin
              nx_raddr  = head_r;
              state_nxt = S_DHEAD;
            end else if (pos_end) begin
              pv_raddr  = tail_r;
              state_nxt = S_DTAIL;
            end else begin
              nx_raddr  = head_r;
              cur_nxt   = head_r;
              steps_nxt = SLOT_W'(pos_r - POS_W'(2));
              state_nxt = S_WALK;
            end
          end
        endcase
      end

      S_WALK: begin
        if (steps_r == '0) begin
          left_nxt = cur_r;
          if (act_r == ACT_DEL) begin
            new_nxt   = nx_rdata;
            nx_raddr  = nx_rdata;
            state_nxt = S_DMID;
          end else begin
            right_nxt = nx_rdata;
            kind_nxt  = K_MID;
            state_nxt = S_POP;
          end
        end else begin
          cur_nxt   = nx_rdata;
          nx_raddr  = nx_rdata;
          steps_nxt = steps_r - SLOT_W'(1);
        end
      end

      S_POP: begin
        sv_we    = 1'b1;
        free_nxt = pop_idx;
        if (fresh) begin
          min_nxt = pop_idx;
        end
        new_nxt   = pop_slot;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_OUT;
        unique case (kind_r)
          K_FIRST: begin
            head_nxt  = pop_slot;
            tail_nxt  = pop_slot;
            hval_nxt  = val_r;
            tval_nxt  = val_r;
            count_nxt = CNT_W'(1);
          end
          K_HEAD: begin
            nx_we    = 1'b1;
            nx_waddr = pop_slot;
            nx_wdata = head_r;
            pv_we    = 1'b1;
            pv_waddr = head_r;
            pv_wdata = pop_slot;
            head_nxt = pop_slot;
            hval_nxt = val_r;
          end
          K_TAIL: begin
            pv_we    = 1'b1;
            pv_waddr = pop_slot;
            pv_wdata = tail_r;
            nx_we    = 1'b1;
            nx_waddr = tail_r;
            nx_wdata = pop_slot;
            tail_nxt = pop_slot;
            tval_nxt = val_r;
          end
          K_MID: begin
            pv_we     = 1'b1;
            pv_waddr  = right_r;
            pv_wdata  = pop_slot;
            nx_we     = 1'b1;
            nx_waddr  = pop_slot;
            nx_wdata  = right_r;
            state_nxt = S_LINK;
          end
        endcase
      end

      S_LINK: begin
        nx_we     = 1'b1;
        nx_waddr  = left_r;
        nx_wdata  = new_r;
        pv_we     = 1'b1;
        pv_waddr  = new_r;
        pv_wdata  = left_r;
        state_nxt = S_OUT;
      end

      S_DMID: begin
        nx_we     = 1'b1;
        nx_waddr  = left_r;
        nx_wdata  = nx_rdata;
        pv_we     = 1'b1;
        pv_waddr  = nx_rdata;
        pv_wdata  = left_r;
        fs_we     = has_room;
        fs_wdata  = new_r;
        free_nxt  = has_room ? free_r + CNT_W'(1) : free_r;
        count_nxt = count_r - CNT_W'(1);
        state_nxt = S_OUT;
      end

      S_DHEAD: begin
        fs_we     = has_room;
        fs_wdata  = head_r;
        free_nxt  = has_room ? free_r + CNT_W'(1) : free_r;
        count_nxt = count_r - CNT_W'(1);
        head_nxt  = nx_rdata;
        sv_raddr  = nx_rdata;
        kind_nxt  = K_HEAD;
        state_nxt = S_VAL;
      end

      S_DTAIL: begin
        fs_we     = has_room;
        fs_wdata  = tail_r;
        free_nxt  = has_room ? free_r + CNT_W'(1) : free_r;
        count_nxt = count_r - CNT_W'(1);
        tail_nxt  = pv_rdata;
        sv_raddr  = pv_rdata;
        kind_nxt  = K_TAIL;
        state_nxt = S_VAL;
      end

      S_VAL: begin
        if (kind_r == K_HEAD) begin
          hval_nxt = sv_rdata;
        end else begin
          tval_nxt = sv_rdata;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {4'b0,
                            empty ? '0 : tval_r,
                            empty ? '0 : hval_r,
                            ~empty,
                            count_r,
                            status_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      count_r      <= '0;
      free_r       <= CNT_W'(CAPACITY);
      min_r        <= CNT_W'(CAPACITY);
      head_r       <= '0;
      tail_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      count_r      <= count_nxt;
      free_r       <= free_nxt;
      min_r        <= min_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
    end
    kind_r      <= kind_nxt;
    status_r    <= status_nxt;
    act_r       <= act_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    hval_r      <= hval_nxt;
    tval_r      <= tval_nxt;
    cur_r       <= cur_nxt;
    steps_r     <= steps_nxt;
    left_r      <= left_nxt;
    right_r     <= right_nxt;
    new_r       <= new_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== src/pdll_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the node values, the link arrays and the free-slot stack.
// No dependencies.
module pdll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
